// ----- rtl/core/lcdfmt_pkg.sv -----
// ----------------------------------------------------------------------------
// lcdfmt_pkg
// Shared types, codes and constants of the character-LCD write formatter.
// ----------------------------------------------------------------------------
package lcdfmt_pkg;

    localparam int unsigned OP_W       = 3;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned NUM_W      = 32;
    localparam int unsigned ROW_W      = 2;
    localparam int unsigned COL_W      = 6;
    localparam int unsigned DIGIT_W    = 4;
    localparam int unsigned NUM_DIGITS = 10;
    localparam int unsigned CNT_W      = $clog2(NUM_W);
    localparam int unsigned REM_W      = $clog2(NUM_DIGITS + 1);

    // request codes
    localparam logic [OP_W-1:0] OP_CHAR = 3'd0;
    localparam logic [OP_W-1:0] OP_CMD  = 3'd1;
    localparam logic [OP_W-1:0] OP_POS  = 3'd2;
    localparam logic [OP_W-1:0] OP_NUM  = 3'd3;
    localparam logic [OP_W-1:0] OP_INIT = 3'd4;

    localparam logic [ROW_W-1:0] ROW_TOP    = 2'd0;
    localparam logic [ROW_W-1:0] ROW_BOTTOM = 2'd1;

    localparam logic [BYTE_W-1:0] ROW_BASE    = 8'd128;
    localparam logic [BYTE_W-1:0] ROW1_OFFSET = 8'd64;
    localparam logic [BYTE_W-1:0] ASCII_ZERO  = 8'd48;

    localparam logic [BYTE_W-1:0] INIT_FUNCTION_SET = 8'b0011_1000;
    localparam logic [BYTE_W-1:0] INIT_DISPLAY_ON   = 8'b0000_1100;
    localparam logic [BYTE_W-1:0] INIT_CLEAR        = 8'b0000_0001;

    localparam logic [1:0] INIT_STEP_FUNCTION = 2'd0;
    localparam logic [1:0] INIT_STEP_DISPLAY  = 2'd1;
    localparam logic [1:0] INIT_STEP_CLEAR    = 2'd2;

    localparam logic RS_DATA    = 1'b1;
    localparam logic RS_COMMAND = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SINGLE,
        ST_INIT,
        ST_CONV,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_DABBLE,
        CELL_MOVE
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t mode;
        logic       serial_bit;
    } cell_ctrl_t;

    function automatic logic [BYTE_W-1:0] init_cmd(input logic [1:0] step);
        logic [BYTE_W-1:0] cmd;
        case (step)
            INIT_STEP_FUNCTION: cmd = INIT_FUNCTION_SET;
            INIT_STEP_DISPLAY:  cmd = INIT_DISPLAY_ON;
            default:            cmd = INIT_CLEAR;
        endcase
        return cmd;
    endfunction

endpackage

// ----- rtl/core/char_lcd_write_formatter_top.sv -----
// ----------------------------------------------------------------------------
// char_lcd_write_formatter_top
// Turns character, command, position, number and init requests into LCD writes.
// ----------------------------------------------------------------------------
//  channel  direction  beat contents
//  s_*      in         operation, data_byte, number_value, row_index, column_index
//  m_*      out        lcd_byte, lcd_rs, last_write
//
//  Character and command: one write, held and then moved to the output register.
//  Position: the same for rows 0 and 1; rows 2 and 3 give no write. Init: three
//  command writes. Number: shift-and-add of all 32 bits through the ten-digit cell
//  row, then one write per digit; leading zeros are dropped one a cycle.
//  One request at a time; s_ready rises once its last write sits in the output
//  register. m_ready low stalls writes only. Reset clears control state only.
// ----------------------------------------------------------------------------
module char_lcd_write_formatter_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [lcdfmt_pkg::OP_W-1:0]         s_operation,
    input  logic [lcdfmt_pkg::BYTE_W-1:0]       s_data_byte,
    input  logic [lcdfmt_pkg::NUM_W-1:0]        s_number_value,
    input  logic [lcdfmt_pkg::ROW_W-1:0]        s_row_index,
    input  logic [lcdfmt_pkg::COL_W-1:0]        s_column_index,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [lcdfmt_pkg::BYTE_W-1:0]       m_lcd_byte,
    output logic                                m_lcd_rs,
    output logic                                m_last_write
);

    lcdfmt_pkg::state_t state_reg, state_next;

    logic [lcdfmt_pkg::BYTE_W-1:0] hold_byte_reg, hold_byte_next;
    logic                          hold_rs_reg, hold_rs_next;
    logic [lcdfmt_pkg::NUM_W-1:0]  bin_reg, bin_next;
    logic [lcdfmt_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [1:0]                    step_reg, step_next;
    logic [lcdfmt_pkg::REM_W-1:0]  remain_reg, remain_next;
    logic                          started_reg, started_next;

    logic                          m_valid_reg, m_valid_next;
    logic [lcdfmt_pkg::BYTE_W-1:0] m_byte_reg, m_byte_next;
    logic                          m_rs_reg, m_rs_next;
    logic                          m_last_reg, m_last_next;

    lcdfmt_pkg::cell_ctrl_t         cell_ctrl;
    logic [lcdfmt_pkg::DIGIT_W-1:0] top_digit;
    logic                           out_free;
    logic                           accept;

    lcdfmt_bcd_chain u_chain (
        .aclk      (aclk),
        .ctrl      (cell_ctrl),
        .top_digit (top_digit)
    );

    assign s_ready  = (state_reg == lcdfmt_pkg::ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign m_valid      = m_valid_reg;
    assign m_lcd_byte   = m_byte_reg;
    assign m_lcd_rs     = m_rs_reg;
    assign m_last_write = m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lcdfmt_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_byte_reg <= hold_byte_next;
        hold_rs_reg   <= hold_rs_next;
        bin_reg       <= bin_next;
        count_reg     <= count_next;
        step_reg      <= step_next;
        remain_reg    <= remain_next;
        started_reg   <= started_next;
        m_byte_reg    <= m_byte_next;
        m_rs_reg      <= m_rs_next;
        m_last_reg    <= m_last_next;
    end

    always_comb begin
        state_next      = state_reg;
        hold_byte_next  = hold_byte_reg;
        hold_rs_next    = hold_rs_reg;
        bin_next        = bin_reg;
        count_next      = count_reg;
        step_next       = step_reg;
        remain_next     = remain_reg;
        started_next    = started_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_byte_next     = m_byte_reg;
        m_rs_next       = m_rs_reg;
        m_last_next     = m_last_reg;
        cell_ctrl.mode       = lcdfmt_pkg::CELL_HOLD;
        cell_ctrl.serial_bit = bin_reg[lcdfmt_pkg::NUM_W-1];

        case (state_reg)
            lcdfmt_pkg::ST_IDLE: begin
                if (accept) begin
                    case (s_operation)
                        lcdfmt_pkg::OP_CHAR: begin
                            hold_byte_next = s_data_byte;
                            hold_rs_next   = lcdfmt_pkg::RS_DATA;
                            state_next     = lcdfmt_pkg::ST_SINGLE;
                        end
                        lcdfmt_pkg::OP_CMD: begin
                            hold_byte_next = s_data_byte;
                            hold_rs_next   = lcdfmt_pkg::RS_COMMAND;
                            state_next     = lcdfmt_pkg::ST_SINGLE;
                        end
                        lcdfmt_pkg::OP_POS: begin
                            hold_rs_next = lcdfmt_pkg::RS_COMMAND;
                            if (s_row_index == lcdfmt_pkg::ROW_TOP) begin
                                hold_byte_next = lcdfmt_pkg::ROW_BASE
                                               + {2'b00, s_column_index};
                                state_next     = lcdfmt_pkg::ST_SINGLE;
                            end else if (s_row_index == lcdfmt_pkg::ROW_BOTTOM) begin
                                hold_byte_next = lcdfmt_pkg::ROW_BASE
                                               + lcdfmt_pkg::ROW1_OFFSET
                                               + {2'b00, s_column_index};
                                state_next     = lcdfmt_pkg::ST_SINGLE;
                            end
                            // lower rows of a four-line panel: drop the request
                        end
                        lcdfmt_pkg::OP_NUM: begin
                            bin_next       = s_number_value;
                            count_next     = '0;
                            cell_ctrl.mode = lcdfmt_pkg::CELL_CLEAR;
                            state_next     = lcdfmt_pkg::ST_CONV;
                        end
                        lcdfmt_pkg::OP_INIT: begin
                            step_next  = lcdfmt_pkg::INIT_STEP_FUNCTION;
                            state_next = lcdfmt_pkg::ST_INIT;
                        end
                        default: begin
                            state_next = lcdfmt_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            lcdfmt_pkg::ST_SINGLE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = hold_byte_reg;
                    m_rs_next    = hold_rs_reg;
                    m_last_next  = 1'b1;
                    state_next   = lcdfmt_pkg::ST_IDLE;
                end
            end

            lcdfmt_pkg::ST_INIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = lcdfmt_pkg::init_cmd(step_reg);
                    m_rs_next    = lcdfmt_pkg::RS_COMMAND;
                    m_last_next  = (step_reg == lcdfmt_pkg::INIT_STEP_CLEAR);
                    step_next    = step_reg + 2'd1;
                    if (step_reg == lcdfmt_pkg::INIT_STEP_CLEAR) begin
                        state_next = lcdfmt_pkg::ST_IDLE;
                    end
                end
            end

            lcdfmt_pkg::ST_CONV: begin
                // shift the binary value into the digit row, msb first
                cell_ctrl.mode = lcdfmt_pkg::CELL_DABBLE;
                bin_next       = {bin_reg[lcdfmt_pkg::NUM_W-2:0], 1'b0};
                count_next     = count_reg + 1'b1;
                if (count_reg == lcdfmt_pkg::CNT_W'(lcdfmt_pkg::NUM_W - 1)) begin
                    remain_next  = lcdfmt_pkg::REM_W'(lcdfmt_pkg::NUM_DIGITS);
                    started_next = 1'b0;
                    state_next   = lcdfmt_pkg::ST_EMIT;
                end
            end

            lcdfmt_pkg::ST_EMIT: begin
                if (!started_reg && top_digit == '0
                        && remain_reg != lcdfmt_pkg::REM_W'(1)) begin
                    // drop a leading zero without a write
                    cell_ctrl.mode = lcdfmt_pkg::CELL_MOVE;
                    remain_next    = remain_reg - 1'b1;
                end else if (out_free) begin
                    cell_ctrl.mode = lcdfmt_pkg::CELL_MOVE;
                    started_next   = 1'b1;
                    remain_next    = remain_reg - 1'b1;
                    m_valid_next   = 1'b1;
                    m_byte_next    = lcdfmt_pkg::ASCII_ZERO + {4'b0000, top_digit};
                    m_rs_next      = lcdfmt_pkg::RS_DATA;
                    m_last_next    = (remain_reg == lcdfmt_pkg::REM_W'(1));
                    if (remain_reg == lcdfmt_pkg::REM_W'(1)) begin
                        state_next = lcdfmt_pkg::ST_IDLE;
                    end
                end
            end

            default: begin
                state_next = lcdfmt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/lcdfmt_bcd_cell.sv -----
// ----------------------------------------------------------------------------
// lcdfmt_bcd_cell
// One decimal digit of the conversion row: clear, add-3 and shift, hold or pass on.
// ----------------------------------------------------------------------------
module lcdfmt_bcd_cell (
    input  logic                                aclk,
    input  lcdfmt_pkg::cell_mode_t              mode,
    input  logic                                bit_in,
    input  logic [lcdfmt_pkg::DIGIT_W-1:0]      digit_in,
    output logic [lcdfmt_pkg::DIGIT_W-1:0]      digit_out,
    output logic                                carry_out
);

    logic [lcdfmt_pkg::DIGIT_W-1:0] digit_reg;
    logic [lcdfmt_pkg::DIGIT_W-1:0] adj;

    // correct before the shift so the digit never passes nine
    assign adj       = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
    assign carry_out = adj[lcdfmt_pkg::DIGIT_W-1];
    assign digit_out = digit_reg;

    always_ff @(posedge aclk) begin
        case (mode)
            lcdfmt_pkg::CELL_CLEAR:  digit_reg <= '0;
            lcdfmt_pkg::CELL_DABBLE: digit_reg <= {adj[lcdfmt_pkg::DIGIT_W-2:0], bit_in};
            lcdfmt_pkg::CELL_MOVE:   digit_reg <= digit_in;
            default:                 digit_reg <= digit_reg;
        endcase
    end

endmodule

// ----- rtl/core/lcdfmt_bcd_chain.sv -----
// ----------------------------------------------------------------------------
// lcdfmt_bcd_chain
// Row of digit cells; cell 0 is least significant, the top cell feeds the bus.
// ----------------------------------------------------------------------------
module lcdfmt_bcd_chain (
    input  logic                                aclk,
    input  lcdfmt_pkg::cell_ctrl_t              ctrl,
    output logic [lcdfmt_pkg::DIGIT_W-1:0]      top_digit
);

    localparam int unsigned N = lcdfmt_pkg::NUM_DIGITS;

    logic [N-1:0][lcdfmt_pkg::DIGIT_W-1:0] digits;
    logic [N-1:0]                          carries;

    genvar i;
    generate
        for (i = 0; i < N; i++) begin : g_cell
            if (i == 0) begin : g_first
                lcdfmt_bcd_cell u_cell (
                    .aclk      (aclk),
                    .mode      (ctrl.mode),
                    .bit_in    (ctrl.serial_bit),
                    .digit_in  ('0),
                    .digit_out (digits[i]),
                    .carry_out (carries[i])
                );
            end else begin : g_next
                lcdfmt_bcd_cell u_cell (
                    .aclk      (aclk),
                    .mode      (ctrl.mode),
                    .bit_in    (carries[i-1]),
                    .digit_in  (digits[i-1]),
                    .digit_out (digits[i]),
                    .carry_out (carries[i])
                );
            end
        end
    endgenerate

    assign top_digit = digits[N-1];

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the character-LCD write formatter. A queue of
// requests, directed corner cases first and then random ones, feeds a driver
// with random gaps. A monitor with random back-pressure compares every bus
// write against the writes predicted for the accepted requests, in order.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned DRAIN_CYCLES = 80;
    localparam int unsigned RANDOM_REQS  = 327;

    typedef struct {
        logic [lcdfmt_pkg::OP_W-1:0]   operation;
        logic [lcdfmt_pkg::BYTE_W-1:0] data_byte;
        logic [lcdfmt_pkg::NUM_W-1:0]  number_value;
        logic [lcdfmt_pkg::ROW_W-1:0]  row_index;
        logic [lcdfmt_pkg::COL_W-1:0]  column_index;
        bit                            no_gap;
    } lcd_req_t;

    typedef struct {
        logic [lcdfmt_pkg::BYTE_W-1:0] code;
        logic                          rs;
        logic                          last;
    } lcd_write_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic [lcdfmt_pkg::OP_W-1:0]     s_operation = '0;
    logic [lcdfmt_pkg::BYTE_W-1:0]   s_data_byte = '0;
    logic [lcdfmt_pkg::NUM_W-1:0]    s_number_value = '0;
    logic [lcdfmt_pkg::ROW_W-1:0]    s_row_index = '0;
    logic [lcdfmt_pkg::COL_W-1:0]    s_column_index = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic [lcdfmt_pkg::BYTE_W-1:0]   m_lcd_byte;
    logic                            m_lcd_rs;
    logic                            m_last_write;

    lcd_req_t   pending_reqs[$];
    lcd_write_t expected_writes[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned send_gap = 0;
    int unsigned recv_stall = 0;
    bit          quiet = 1'b0;

    char_lcd_write_formatter_top DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_data_byte    (s_data_byte),
        .s_number_value (s_number_value),
        .s_row_index    (s_row_index),
        .s_column_index (s_column_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_lcd_byte     (m_lcd_byte),
        .m_lcd_rs       (m_lcd_rs),
        .m_last_write   (m_last_write)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned gap_len();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Append the bus writes that one request produces.
    function automatic void predict_writes(input lcd_req_t req);
        lcd_write_t                     run[$];
        lcd_write_t                     w;
        logic [lcdfmt_pkg::NUM_W-1:0]   rest;
        logic [lcdfmt_pkg::DIGIT_W-1:0] digits[lcdfmt_pkg::NUM_DIGITS];
        int                             nd;
        nd = 0;
        case (req.operation)
            lcdfmt_pkg::OP_CHAR: run.push_back('{req.data_byte, lcdfmt_pkg::RS_DATA, 1'b0});
            lcdfmt_pkg::OP_CMD:  run.push_back('{req.data_byte, lcdfmt_pkg::RS_COMMAND, 1'b0});
            lcdfmt_pkg::OP_POS: begin
                if (req.row_index == lcdfmt_pkg::ROW_TOP)
                    run.push_back('{lcdfmt_pkg::ROW_BASE + {2'b00, req.column_index},
                                    lcdfmt_pkg::RS_COMMAND, 1'b0});
                else if (req.row_index == lcdfmt_pkg::ROW_BOTTOM)
                    run.push_back('{lcdfmt_pkg::ROW_BASE + lcdfmt_pkg::ROW1_OFFSET
                                    + {2'b00, req.column_index},
                                    lcdfmt_pkg::RS_COMMAND, 1'b0});
            end
            lcdfmt_pkg::OP_NUM: begin
                rest = req.number_value;
                do begin
                    digits[nd] = 4'(rest % 10);
                    rest = rest / 10;
                    nd++;
                end while (rest != 0 && nd < int'(lcdfmt_pkg::NUM_DIGITS));
                for (int i = nd - 1; i >= 0; i--)
                    run.push_back('{lcdfmt_pkg::ASCII_ZERO + {4'b0000, digits[i]},
                                    lcdfmt_pkg::RS_DATA, 1'b0});
            end
            lcdfmt_pkg::OP_INIT: begin
                run.push_back('{lcdfmt_pkg::INIT_FUNCTION_SET, lcdfmt_pkg::RS_COMMAND, 1'b0});
                run.push_back('{lcdfmt_pkg::INIT_DISPLAY_ON, lcdfmt_pkg::RS_COMMAND, 1'b0});
                run.push_back('{lcdfmt_pkg::INIT_CLEAR, lcdfmt_pkg::RS_COMMAND, 1'b0});
            end
            default: ;
        endcase
        if (run.size() > 0) run[run.size() - 1].last = 1'b1;
        foreach (run[i]) begin
            w = run[i];
            expected_writes.push_back(w);
        end
    endfunction

    function automatic void add_req(input logic [lcdfmt_pkg::OP_W-1:0]   op,
                                    input logic [lcdfmt_pkg::BYTE_W-1:0] db,
                                    input logic [lcdfmt_pkg::NUM_W-1:0]  num,
                                    input logic [lcdfmt_pkg::ROW_W-1:0]  row,
                                    input logic [lcdfmt_pkg::COL_W-1:0]  col,
                                    input bit                            no_gap);
        lcd_req_t req;
        req = '{op, db, num, row, col, no_gap};
        pending_reqs.push_back(req);
    endfunction

    // Decimal value of a chosen length, with edges around powers of ten.
    function automatic logic [lcdfmt_pkg::NUM_W-1:0] rand_number();
        longint unsigned pow10;
        int unsigned     ndig;
        int unsigned     pick;
        ndig = $urandom_range(1, 10);
        pow10 = 1;
        for (int i = 0; i < ndig; i++) pow10 = pow10 * 10;
        pick = $urandom_range(0, 9);
        if (ndig == 10) begin
            if (pick == 0) return 32'hFFFF_FFFF;
            if (pick == 1) return 32'd1_000_000_000;
            return $urandom;
        end
        if (pick == 0) return 32'(pow10 - 1);
        if (pick == 1) return 32'(pow10 / 10);
        return 32'(longint'($urandom) % pow10);
    endfunction

    // Driver: hold the beat until accepted, then predict and advance.
    always @(posedge aclk) begin
        lcd_req_t req;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                predict_writes('{s_operation, s_data_byte, s_number_value,
                                 s_row_index, s_column_index, 1'b0});
            end
            if (send_gap != 0) begin
                s_valid  <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_reqs.size() > 0) begin
                req = pending_reqs.pop_front();
                s_valid        <= 1'b1;
                s_operation    <= req.operation;
                s_data_byte    <= req.data_byte;
                s_number_value <= req.number_value;
                s_row_index    <= req.row_index;
                s_column_index <= req.column_index;
                quiet          <= req.no_gap;
                send_gap       <= req.no_gap ? 0 : gap_len();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: random back-pressure and in-order check of each write beat.
    always @(posedge aclk) begin
        lcd_write_t want;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            recv_stall <= 0;
        end else begin
            if (recv_stall != 0) begin
                m_ready    <= 1'b0;
                recv_stall <= recv_stall - 1;
            end else begin
                m_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 3) == 0) recv_stall <= gap_len();
            end
            if (m_valid && m_ready) begin
                if (expected_writes.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: extra write: expected none, actual %02h rs=%0b last=%0b",
                             $time, m_lcd_byte, m_lcd_rs, m_last_write);
                end else begin
                    want = expected_writes.pop_front();
                    if (m_lcd_byte !== want.code) begin
                        mismatch_count++;
                        $display("%0t: lcd_byte mismatch: expected %02h, actual %02h",
                                 $time, want.code, m_lcd_byte);
                    end
                    if (m_lcd_rs !== want.rs) begin
                        mismatch_count++;
                        $display("%0t: lcd_rs mismatch: expected %0b, actual %0b",
                                 $time, want.rs, m_lcd_rs);
                    end
                    if (m_last_write !== want.last) begin
                        mismatch_count++;
                        $display("%0t: last_write mismatch: expected %0b, actual %0b",
                                 $time, want.last, m_last_write);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** char_lcd_write_formatter_top: FAILED **");
            $finish;
        end
    end

    initial begin
        lcd_req_t    req;
        int unsigned pick;

        // Directed corners; unused fields carry random values.
        add_req(lcdfmt_pkg::OP_CHAR, 8'h00, $urandom, 2'($urandom), 6'($urandom), 1'b0);
        add_req(lcdfmt_pkg::OP_CHAR, 8'hFF, $urandom, 2'($urandom), 6'($urandom), 1'b0);
        add_req(lcdfmt_pkg::OP_CMD,  8'h00, $urandom, 2'($urandom), 6'($urandom), 1'b0);
        add_req(lcdfmt_pkg::OP_CMD,  8'hFF, $urandom, 2'($urandom), 6'($urandom), 1'b0);
        add_req(lcdfmt_pkg::OP_POS, 8'($urandom), $urandom, lcdfmt_pkg::ROW_TOP, 6'd0, 1'b0);
        add_req(lcdfmt_pkg::OP_POS, 8'($urandom), $urandom, lcdfmt_pkg::ROW_TOP, 6'd63, 1'b0);
        add_req(lcdfmt_pkg::OP_POS, 8'($urandom), $urandom, lcdfmt_pkg::ROW_BOTTOM, 6'd0,
                1'b0);
        add_req(lcdfmt_pkg::OP_POS, 8'($urandom), $urandom, lcdfmt_pkg::ROW_BOTTOM, 6'd63,
                1'b0);
        add_req(lcdfmt_pkg::OP_POS, 8'($urandom), $urandom, 2'd2, 6'($urandom), 1'b0);
        add_req(lcdfmt_pkg::OP_POS, 8'($urandom), $urandom, 2'd3, 6'($urandom), 1'b0);
        add_req(lcdfmt_pkg::OP_NUM, 8'($urandom), 32'd0, 2'($urandom), 6'($urandom), 1'b0);
        add_req(lcdfmt_pkg::OP_NUM, 8'($urandom), 32'd9, 2'($urandom), 6'($urandom), 1'b0);
        add_req(lcdfmt_pkg::OP_NUM, 8'($urandom), 32'd10, 2'($urandom), 6'($urandom), 1'b0);
        add_req(lcdfmt_pkg::OP_NUM, 8'($urandom), 32'd999_999_999, 2'($urandom),
                6'($urandom), 1'b0);
        add_req(lcdfmt_pkg::OP_NUM, 8'($urandom), 32'd1_000_000_000, 2'($urandom),
                6'($urandom), 1'b0);
        add_req(lcdfmt_pkg::OP_NUM, 8'($urandom), 32'd1_234_567_890, 2'($urandom),
                6'($urandom), 1'b0);
        add_req(lcdfmt_pkg::OP_NUM, 8'($urandom), 32'hFFFF_FFFF, 2'($urandom),
                6'($urandom), 1'b0);
        add_req(lcdfmt_pkg::OP_INIT, 8'($urandom), $urandom, 2'($urandom), 6'($urandom),
                1'b0);
        add_req(3'd5, 8'($urandom), $urandom, 2'($urandom), 6'($urandom), 1'b0);
        add_req(3'd6, 8'($urandom), $urandom, 2'($urandom), 6'($urandom), 1'b0);
        add_req(3'd7, 8'($urandom), $urandom, 2'($urandom), 6'($urandom), 1'b0);
        add_req(lcdfmt_pkg::OP_INIT, 8'($urandom), $urandom, 2'($urandom), 6'($urandom),
                1'b1);
        add_req(lcdfmt_pkg::OP_NUM, 8'($urandom), 32'd4_000_000_000, 2'($urandom),
                6'($urandom), 1'b1);

        // Random requests, with one stretch sent back to back.
        for (int unsigned n = 0; n < RANDOM_REQS; n++) begin
            pick = $urandom_range(0, 99);
            req.data_byte    = 8'($urandom);
            req.number_value = (pick < 50) ? rand_number() : $urandom;
            req.row_index    = 2'($urandom);
            req.column_index = 6'($urandom);
            req.no_gap       = (n >= 120 && n < 170);
            if (pick < 15)      req.operation = lcdfmt_pkg::OP_CHAR;
            else if (pick < 28) req.operation = lcdfmt_pkg::OP_CMD;
            else if (pick < 43) req.operation = lcdfmt_pkg::OP_POS;
            else if (pick < 85) req.operation = lcdfmt_pkg::OP_NUM;
            else if (pick < 95) req.operation = lcdfmt_pkg::OP_INIT;
            else                req.operation = 3'($urandom_range(5, 7));
            pending_reqs.push_back(req);
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        @(posedge aclk);
        while (pending_reqs.size() > 0 || s_valid) @(posedge aclk);
        while (expected_writes.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (expected_writes.size() > 0) begin
            mismatch_count++;
            $display("%0t: %0d expected writes never arrived", $time, expected_writes.size());
        end
        if (mismatch_count == 0) begin
            $display("** char_lcd_write_formatter_top: PASSED **");
        end else begin
            $display("** char_lcd_write_formatter_top: FAILED **");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/lcdfmt_pkg.sv
rtl/core/lcdfmt_bcd_cell.sv
rtl/core/lcdfmt_bcd_chain.sv
rtl/core/char_lcd_write_formatter_top.sv
bench/tb_top.sv
